FILE: sv/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

  // Fixed field widths of the stream items.
  localparam int REQ_W   = 27;
  localparam int OFF_W   = 26;
  localparam int PAGES_W = 3;
  localparam int STAT_W  = 2;
  // Width used for unit arithmetic on requests, starts and ends.
  localparam int XW      = REQ_W + 1;

  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_MAX_PAGES    = 4;
  localparam int DEF_UNIT_BYTES   = 128;
  localparam int DEF_PAGE_BYTES   = 16777216;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_OVERLAP = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_A,
    S_SCAN_F,
    S_FDEC,
    S_SHD_RD,
    S_SHD_WR,
    S_SHU_RD,
    S_SHU_WR,
    S_INS,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

FILE: sv/first_fit_segment_allocator.sv
`default_nettype none
// First-fit allocator over a pool of pool_pages pages, kept as an
// address-ordered table of free segments (start, length) in units.
// Input channel in_*: in_tuser is the operation (0 allocate, 1 free);
// in_tdata carries request_bytes and free_offset. Each input item yields
// exactly one result item on out_* with block_offset, status and
// available_bytes, unless a cfg write cuts the item short.
// Timing: an item walks the segment table one entry per cycle. An
// exact-fit allocate or a merging free that removes an entry moves the
// later entries down, and a free that inserts moves them up, each
// entry through a read state and a write state (S_SHD_RD/S_SHD_WR,
// S_SHU_RD/S_SHU_WR), set by the single read and single write port of
// the segment memory.
// Reset and any cfg write rebuild the table as one segment covering the
// whole pool in state S_INIT, during which in_tready is low.
// The result waits in an output register; a new item is accepted while
// it waits, and the block holds a finished item until that register
// frees up when the receiver stalls.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_PAGES    = DEF_MAX_PAGES,
  parameter int UNIT_BYTES   = DEF_UNIT_BYTES,
  parameter int PAGE_BYTES   = DEF_PAGE_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // [26:0] request_bytes, [52:27] free_offset, [55:53] zero
  input  wire logic [55:0]        in_tdata,
  // [0] operation
  input  wire logic               in_tuser,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [25:0] block_offset, [27:26] status, [54:28] available_bytes, [55] zero
  output logic      [55:0]        out_tdata,
  input  wire logic               cfg_wr_en,
  input  wire logic [PAGES_W-1:0] cfg_wr_data
);

  localparam int SH     = $clog2(UNIT_BYTES);
  localparam int PAGE_U = PAGE_BYTES / UNIT_BYTES;
  localparam int LEN_W  = $clog2(MAX_PAGES * PAGE_U + 1);
  localparam int AW     = $clog2(MAX_SEGMENTS);
  localparam int CW     = $clog2(MAX_SEGMENTS + 1);
  localparam int PGC_W  = $clog2(MAX_PAGES + 1) + 1;
  localparam int EW     = 2 * LEN_W;

  state_t state_r, state_nxt;

  logic [PAGES_W-1:0] pages_r, pages_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   avail_r, avail_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [XW-1:0]      units_r, units_nxt;
  logic [XW-1:0]      s_r, s_nxt;
  logic [XW-1:0]      e_r, e_nxt;
  logic [EW-1:0]      prev_r, prev_nxt;
  logic [EW-1:0]      next_r, next_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  status_t            stat_r, stat_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [OFF_W-1:0]   out_off_r, out_off_nxt;
  status_t            out_stat_r, out_stat_nxt;
  logic [LEN_W-1:0]   out_avail_r, out_avail_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [EW-1:0]      mem_wdata, rdata;

  ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Pool size in units, with pages clamped to 1..MAX_PAGES.
  logic [PGC_W-1:0] pages_c;
  logic [LEN_W-1:0] pool_units;
  always_comb begin
    pages_c = PGC_W'(pages_r);
    if (pages_r == '0) begin
      pages_c = PGC_W'(1);
    end else if (PGC_W'(pages_r) > PGC_W'(MAX_PAGES)) begin
      pages_c = PGC_W'(MAX_PAGES);
    end
    pool_units = LEN_W'(LEN_W'(pages_c) * LEN_W'(PAGE_U));
  end

  // Incoming item decode.
  logic [REQ_W-1:0] in_bytes;
  logic [OFF_W-1:0] in_off;
  logic             in_fire;
  logic [XW-1:0]    in_units, in_s, in_e;
  assign in_bytes = in_tdata[REQ_W-1:0];
  assign in_off   = in_tdata[REQ_W+OFF_W-1:REQ_W];
  assign in_fire  = in_tvalid && in_tready;
  always_comb begin
    in_units = XW'(in_bytes >> SH) + XW'(|in_bytes[SH-1:0]);
    if (in_units == '0) begin
      in_units = XW'(1);
    end
    in_s = XW'(in_off >> SH);
    in_e = in_s + in_units;
  end

  // Decision flags shared by the next-state and datapath logic.
  logic [LEN_W-1:0] rd_start, rd_len, pv_start, pv_len, nx_start, nx_len;
  logic             idx_v, a_fit, a_exact, f_adv;
  logic             has_prev, has_next, f_ovl, m_prev, m_next, tbl_full;
  logic             rm_more, out_free, pool_bad;
  logic [XW-1:0]    pe;
  always_comb begin
    rd_start = rdata[EW-1:LEN_W];
    rd_len   = rdata[LEN_W-1:0];
    pv_start = prev_r[EW-1:LEN_W];
    pv_len   = prev_r[LEN_W-1:0];
    nx_start = next_r[EW-1:LEN_W];
    nx_len   = next_r[LEN_W-1:0];
    idx_v    = idx_r < cnt_r;
    a_fit    = idx_v && (XW'(rd_len) >= units_r);
    a_exact  = XW'(rd_len) == units_r;
    f_adv    = idx_v && (XW'(rd_start) < s_r);
    has_prev = idx_r != '0;
    has_next = idx_v;
    pe       = XW'(pv_start) + XW'(pv_len);
    f_ovl    = (has_prev && (pe > s_r)) || (has_next && (e_r > XW'(nx_start)));
    m_prev   = has_prev && (pe == s_r);
    m_next   = has_next && (e_r == XW'(nx_start));
    tbl_full = cnt_r >= CW'(MAX_SEGMENTS);
    rm_more  = (idx_r + CW'(1)) < cnt_r;
    out_free = !out_vld_r || out_tready;
    pool_bad = in_e > XW'(pool_units);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_tuser) == OP_ALLOC) begin
            state_nxt = S_SCAN_A;
          end else if (pool_bad) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN_F;
          end
        end
      end
      S_SCAN_A: begin
        if (!idx_v) begin
          state_nxt = S_RESP;
        end else if (a_fit) begin
          state_nxt = (a_exact && rm_more) ? S_SHD_RD : S_RESP;
        end
      end
      S_SCAN_F: begin
        if (!f_adv) begin
          state_nxt = S_FDEC;
        end
      end
      S_FDEC: begin
        priority if (f_ovl) begin
          state_nxt = S_RESP;
        end else if (m_prev && m_next) begin
          state_nxt = rm_more ? S_SHD_RD : S_RESP;
        end else if (m_prev || m_next) begin
          state_nxt = S_RESP;
        end else if (tbl_full) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = (cnt_r == idx_r) ? S_INS : S_SHU_RD;
        end
      end
      S_SHD_RD: state_nxt = S_SHD_WR;
      S_SHD_WR: state_nxt = ((k_r + CW'(2)) < cnt_r) ? S_SHD_RD : S_RESP;
      S_SHU_RD: state_nxt = S_SHU_WR;
      S_SHU_WR: state_nxt = ((k_r - CW'(1)) > idx_r) ? S_SHU_RD : S_INS;
      S_INS:    state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_INIT;
    endcase
    if (cfg_wr_en) begin
      state_nxt = S_INIT;
    end
  end

  assign in_tready = state_r == S_IDLE;

  // Datapath and memory control.
  always_comb begin
    pages_nxt     = cfg_wr_en ? cfg_wr_data : pages_r;
    cnt_nxt       = cnt_r;
    avail_nxt     = avail_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    units_nxt     = units_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    off_nxt       = off_r;
    stat_nxt      = stat_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_off_nxt   = out_off_r;
    out_stat_nxt  = out_stat_r;
    out_avail_nxt = out_avail_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = rdata;
    mem_raddr     = '0;
    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {LEN_W'(0), pool_units};
        cnt_nxt   = CW'(1);
        avail_nxt = pool_units;
      end
      S_IDLE: begin
        idx_nxt   = '0;
        units_nxt = in_units;
        s_nxt     = in_s;
        e_nxt     = in_e;
        off_nxt   = '0;
        stat_nxt  = (op_t'(in_tuser) == OP_FREE && pool_bad) ? STAT_OVERLAP : STAT_OK;
      end
      S_SCAN_A: begin
        mem_raddr = AW'(idx_r + CW'(1));
        if (!idx_v) begin
          stat_nxt = STAT_OOM;
        end else if (a_fit) begin
          off_nxt   = OFF_W'(XW'(rd_start) << SH);
          avail_nxt = avail_r - LEN_W'(units_r);
          if (a_exact) begin
            k_nxt = idx_r;
            if (!rm_more) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {rd_start + LEN_W'(units_r), rd_len - LEN_W'(units_r)};
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SCAN_F: begin
        mem_raddr = AW'(idx_r + CW'(1));
        if (f_adv) begin
          prev_nxt = rdata;
          idx_nxt  = idx_r + CW'(1);
        end else begin
          next_nxt = rdata;
        end
      end
      S_FDEC: begin
        priority if (f_ovl) begin
          stat_nxt = STAT_OVERLAP;
        end else if (m_prev && m_next) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_r - CW'(1));
          mem_wdata = {pv_start, pv_len + LEN_W'(units_r) + nx_len};
          avail_nxt = avail_r + LEN_W'(units_r);
          k_nxt     = idx_r;
          if (!rm_more) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end else if (m_prev) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_r - CW'(1));
          mem_wdata = {pv_start, pv_len + LEN_W'(units_r)};
          avail_nxt = avail_r + LEN_W'(units_r);
        end else if (m_next) begin
          mem_we    = 1'b1;
          mem_wdata = {LEN_W'(s_r), nx_len + LEN_W'(units_r)};
          avail_nxt = avail_r + LEN_W'(units_r);
        end else if (tbl_full) begin
          stat_nxt = STAT_FULL;
        end else begin
          avail_nxt = avail_r + LEN_W'(units_r);
          k_nxt     = cnt_r;
        end
      end
      S_SHD_RD: begin
        mem_raddr = AW'(k_r + CW'(1));
      end
      S_SHD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        k_nxt     = k_r + CW'(1);
        if ((k_r + CW'(2)) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_SHU_RD: begin
        mem_raddr = AW'(k_r - CW'(1));
      end
      S_SHU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        k_nxt     = k_r - CW'(1);
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_wdata = {LEN_W'(s_r), LEN_W'(units_r)};
        cnt_nxt   = cnt_r + CW'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_off_nxt   = off_r;
          out_stat_nxt  = stat_r;
          out_avail_nxt = avail_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      pages_r   <= PAGES_W'(1);
      cnt_r     <= '0;
      avail_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pages_r   <= pages_nxt;
      cnt_r     <= cnt_nxt;
      avail_r   <= avail_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    units_r     <= units_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    prev_r      <= prev_nxt;
    next_r      <= next_nxt;
    off_r       <= off_nxt;
    stat_r      <= stat_nxt;
    out_off_r   <= out_off_nxt;
    out_stat_r  <= out_stat_nxt;
    out_avail_r <= out_avail_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, REQ_W'(XW'(out_avail_r) << SH), out_stat_r, out_off_r};

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count exceeds table size");
  a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INIT) |-> (avail_r <= pool_units))
    else $error("available units exceed pool");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !mem_we)
    else $error("segment memory written outside an operation");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_A || state_r == S_SCAN_F) |-> (idx_r <= cnt_r))
    else $error("scan index ran past segment count");
`endif

endmodule
`default_nettype wire

FILE: sv/ffsa_ram.sv
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: tb/first_fit_segment_allocator_test.sv
`timescale 1ns / 1ps

module first_fit_segment_allocator_test;
  import ffsa_pkg::*;

  typedef struct {
    logic [OFF_W-1:0] offset;
    logic [REQ_W-1:0] bytes;
  } live_block_t;

  typedef struct {
    logic [OFF_W-1:0]  offset;
    status_t           status;
    logic [REQ_W-1:0]  avail;
  } reply_t;

  class alloc_scoreboard;
    int unsigned seg_base[DEF_MAX_SEGMENTS];
    int unsigned seg_len[DEF_MAX_SEGMENTS];
    int unsigned seg_count;
    int unsigned free_units;
    int unsigned pool_units;
    reply_t      pending[$];
    int          errors;

    function void configure(logic [PAGES_W-1:0] pages);
      int unsigned p;
      p = pages;
      if (p < 1) p = 1;
      if (p > DEF_MAX_PAGES) p = DEF_MAX_PAGES;
      pool_units = p * (DEF_PAGE_BYTES / DEF_UNIT_BYTES);
      seg_base[0] = 0;
      seg_len[0] = pool_units;
      seg_count = 1;
      free_units = pool_units;
    endfunction

    function void drop_entry(int unsigned i);
      for (int unsigned k = i; k + 1 < seg_count; k++) begin
        seg_base[k] = seg_base[k + 1];
        seg_len[k] = seg_len[k + 1];
      end
      seg_count--;
    endfunction

    function status_t take_first_fit(int unsigned units, output logic [OFF_W-1:0] offset);
      offset = '0;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (seg_len[i] >= units) begin
          offset = OFF_W'(seg_base[i] * DEF_UNIT_BYTES);
          if (seg_len[i] == units) drop_entry(i);
          else begin
            seg_base[i] += units;
            seg_len[i] -= units;
          end
          free_units -= units;
          return STAT_OK;
        end
      end
      return STAT_OOM;
    endfunction

    function status_t give_back(int unsigned s, int unsigned units);
      int unsigned i;
      int unsigned e;
      int unsigned pe;
      bit join_prev;
      bit join_next;
      i = 0;
      e = s + units;
      join_prev = 0;
      join_next = 0;
      if (e > pool_units) return STAT_OVERLAP;
      while (i < seg_count && seg_base[i] < s) i++;
      if (i > 0) begin
        pe = seg_base[i - 1] + seg_len[i - 1];
        if (pe > s) return STAT_OVERLAP;
        join_prev = (pe == s);
      end
      if (i < seg_count) begin
        if (e > seg_base[i]) return STAT_OVERLAP;
        join_next = (e == seg_base[i]);
      end
      if (join_prev && join_next) begin
        seg_len[i - 1] += units + seg_len[i];
        drop_entry(i);
      end else if (join_prev) begin
        seg_len[i - 1] += units;
      end else if (join_next) begin
        seg_base[i] = s;
        seg_len[i] += units;
      end else begin
        if (seg_count >= DEF_MAX_SEGMENTS) return STAT_FULL;
        for (int unsigned k = seg_count; k > i; k--) begin
          seg_base[k] = seg_base[k - 1];
          seg_len[k] = seg_len[k - 1];
        end
        seg_base[i] = s;
        seg_len[i] = units;
        seg_count++;
      end
      free_units += units;
      return STAT_OK;
    endfunction

    function reply_t note_input(op_t op, logic [REQ_W-1:0] bytes, logic [OFF_W-1:0] off);
      reply_t r;
      int unsigned units;
      units = (int'(bytes) + DEF_UNIT_BYTES - 1) / DEF_UNIT_BYTES;
      if (units == 0) units = 1;
      r.offset = '0;
      if (op == OP_ALLOC) r.status = take_first_fit(units, r.offset);
      else r.status = give_back(int'(off) / DEF_UNIT_BYTES, units);
      if (r.status != STAT_OK) r.offset = '0;
      r.avail = REQ_W'(free_units * DEF_UNIT_BYTES);
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(logic [55:0] d);
      reply_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (d[25:0] !== r.offset) begin
        $display("%0t: block_offset expected %h actual %h", $time, r.offset, d[25:0]);
        errors++;
      end
      if (d[27:26] !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, d[27:26]);
        errors++;
      end
      if (d[54:28] !== r.avail) begin
        $display("%0t: available_bytes expected %h actual %h", $time, r.avail, d[54:28]);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_tvalid = 0;
  logic               in_tready;
  logic [55:0]        in_tdata = '0;
  logic               in_tuser = 0;
  logic               out_tvalid;
  logic               out_tready = 0;
  logic [55:0]        out_tdata;
  logic               cfg_wr_en = 0;
  logic [PAGES_W-1:0] cfg_wr_data = '0;

  alloc_scoreboard sb = new();
  live_block_t     live[$];
  bit              quiet = 0;
  bit              hold_req = 0;
  bit              tx_gaps = 1;
  int              stuck_cycles = 0;

  always #4 clk = ~clk;

  first_fit_segment_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Results are checked here; the sender records its own items as they are taken.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || !rst_n ||
        (sb.pending.size() == 0 && !in_tvalid)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles > 20000) begin
        $display("first_fit_segment_allocator_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
        out_tready <= 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_tready <= 0;
        repeat (n) @(posedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_item(op_t op, logic [REQ_W-1:0] bytes, logic [OFF_W-1:0] off);
    reply_t r;
    int n;
    if (!quiet && tx_gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 11);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {3'b000, off, bytes};
    do @(posedge clk); while (!in_tready);
    r = sb.note_input(op, bytes, off);
    if (op == OP_ALLOC && r.status == STAT_OK) live.push_back('{r.offset, bytes});
  endtask

  task automatic settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_pages(logic [PAGES_W-1:0] pages);
    settle();
    cfg_wr_en <= 1;
    cfg_wr_data <= pages;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.configure(pages);
    live.delete();
  endtask

  task automatic free_random_live();
    int idx;
    live_block_t b;
    idx = $urandom_range(0, live.size() - 1);
    b = live[idx];
    live.delete(idx);
    send_item(OP_FREE, b.bytes, b.offset);
  endtask

  task automatic random_item();
    logic [REQ_W-1:0] bytes;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 9))
        0: bytes = REQ_W'($urandom);
        1: bytes = REQ_W'($urandom_range(0, 1 << 24));
        default: bytes = REQ_W'($urandom_range(0, 8192));
      endcase
      send_item(OP_ALLOC, bytes, '0);
    end else if (pick < 88 && live.size() != 0) begin
      free_random_live();
    end else begin
      // Stray frees: random spans, overlaps and blocks past the pool.
      send_item(OP_FREE, ($urandom_range(0, 3) == 0) ? REQ_W'($urandom)
                : REQ_W'($urandom_range(0, 4096)), OFF_W'($urandom));
    end
  endtask

  initial begin
    logic [PAGES_W-1:0] page_plan[4];
    sb.configure(1);
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: rounding, first fit, exhaustion, bad frees, merges.
    send_item(OP_ALLOC, 0, '0);
    send_item(OP_ALLOC, 1, '0);
    send_item(OP_ALLOC, 128, '0);
    send_item(OP_ALLOC, 129, '0);
    send_item(OP_ALLOC, 27'h4000000, '0);
    send_item(OP_ALLOC, 27'h7FFFFFF, '0);
    send_item(OP_FREE, 0, 26'h3FFFFFF);
    send_item(OP_FREE, 27'h7FFFFFF, '0);
    send_item(OP_FREE, 1, 26'd128 + 26'd77);
    send_item(OP_FREE, 1, 26'd1024);
    send_item(OP_FREE, 128, 26'd0);
    send_item(OP_FREE, 256, 26'd256);
    send_item(OP_FREE, 128, 26'd128);
    live.delete();
    // A whole-pool request while a unit is still held; then small frees and allocs.
    send_item(OP_ALLOC, 27'h1000000, '0);
    send_item(OP_ALLOC, 1, '0);
    send_item(OP_FREE, 128, 26'd4096);
    send_item(OP_FREE, 128, 26'd4224);
    send_item(OP_FREE, 128, 26'd0);
    send_item(OP_ALLOC, 256, '0);

    write_pages(0);
    send_item(OP_ALLOC, 27'h1000000, '0);
    write_pages(7);
    send_item(OP_ALLOC, 27'h4000000, '0);
    send_item(OP_FREE, 27'h4000000, '0);
    write_pages(5);
    send_item(OP_FREE, 128, 26'h3FFFF80);

    // Fragment the table until an insert finds it full, then merge back.
    write_pages(1);
    live.delete();
    send_item(OP_ALLOC, REQ_W'(520 * 128), '0);
    for (int k = 0; k < 520; k += 2) begin
      send_item(OP_FREE, REQ_W'($urandom_range(0, 128)), OFF_W'(k * 128));
    end
    for (int k = 1; k < 520; k += 2) send_item(OP_FREE, 128, OFF_W'(k * 128));
    for (int k = 0; k < 80; k += 2) send_item(OP_FREE, 1, OFF_W'(k * 128));
    live.delete();

    // Random phases across pool sizes; the receiver stalls long in the first one.
    page_plan = '{2, 4, 3, 1};
    for (int ph = 0; ph < 4; ph++) begin
      write_pages(page_plan[ph]);
      if (ph == 0) begin
        hold_req = 1;
        tx_gaps = 0;
        for (int k = 0; k < 40; k++) random_item();
        tx_gaps = 1;
      end
      if (ph == 3) quiet = 1;
      for (int k = 0; k < 80; k++) random_item();
    end

    in_tvalid <= 0;
    for (int w = 0; w < 100000 && sb.pending.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("first_fit_segment_allocator_test: PASS");
    end else begin
      $display("first_fit_segment_allocator_test: FAIL");
    end
    $finish;
  end
endmodule
